>>> hdl/cfs_pkg.sv
`timescale 1ns / 1ps
// Package for the CRC-16 checked frame sync block.
// Holds reset values, the polynomial, register indexes and the CRC unit control type.
package cfs_pkg;

  localparam int FRAME_BYTES_DEF = 10;

  localparam logic [7:0]  HEADER_RESET = 8'h61;
  localparam logic [15:0] SEED_RESET   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED   = 2'd1;

  // first: start from the seed rather than the running value
  // step:  fold one byte into the CRC this cycle
  typedef struct packed {
    logic first;
    logic step;
  } crc_ctrl_t;

endpackage

>>> hdl/cfs_if.sv
`timescale 1ns / 1ps
// Handshake channels of the frame sync block: received bytes, frame bytes, register writes.
// Depends on cfs_pkg for the register port widths.
interface cfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfs_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface cfs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cfs_pkg::CFG_INDEX_W-1:0]    reg_index;
  logic [cfs_pkg::CFG_DATA_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hdl/cfs_crc16.sv
`timescale 1ns / 1ps
// Byte-serial CRC-16 unit, polynomial 0x1021, MSB first, no reflection, no final XOR.
// Depends on cfs_pkg for the polynomial and the control struct.
module cfs_crc16 (
  input  logic               clk,
  input  cfs_pkg::crc_ctrl_t ctrl,
  input  logic [15:0]        seed,
  input  logic [7:0]         data,
  output logic [15:0]        crc
);

  logic [15:0] crc_next;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ cfs_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign crc_next = crc_byte(ctrl.first ? seed : crc, data);

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      crc <= crc_next;
    end
  end

endmodule

>>> hdl/crc16_checked_frame_sync.sv
`timescale 1ns / 1ps
// Flow: a byte that completes a good frame starts a check pass, after which the frame
//   leaves at one byte per cycle while taken.
// Throughput: one byte per cycle while the window fills; a full window then goes through
//   a check pass (one byte a cycle through the CRC unit) and, if good, is emitted.
// Reset: synchronous, clears window fill, state and registers (header 0x61, seed 0xFFFF).
//
// Top level of the CRC-16 checked frame sync. Uses cfs_pkg, the cfs interfaces and
// cfs_crc16.
//
// The window is a row of byte registers, oldest in entry 0. Incoming bytes are written
// at the fill position. Once full, the row rotates one place per cycle so every byte
// passes entry 0: the header is compared there, the first FRAME_BYTES-2 bytes go through
// the CRC unit, and the trailing two are captured as the received CRC. After a full turn
// the row is back in order. A good frame is then emitted from entry 0, rotating on each
// taken item; a bad one drops its oldest byte and scanning carries on.
module crc16_checked_frame_sync #(
  parameter int FRAME_BYTES = cfs_pkg::FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  cfs_cfg_if.sink         cfg,
  cfs_byte_if.sink        rx,
  cfs_frame_if.source     frame
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] HI_IDX   = IDX_W'(FRAME_BYTES - 2);
  localparam logic [IDX_W-1:0] CRC_END  = IDX_W'(FRAME_BYTES - 3);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   fill;       // bytes held while idle, never FRAME_BYTES
  logic [IDX_W-1:0]   cnt;        // position within the check or emit pass
  logic [7:0]         win [FRAME_BYTES];
  logic [7:0]         win_rot1 [FRAME_BYTES];  // rotated by one: next byte into entry 0
  logic [7:0]         win_rot2 [FRAME_BYTES];  // rotated by two: used to drop the oldest
  logic [7:0]         header_byte;
  logic [15:0]        crc_seed;
  logic               hdr_ok;
  logic [7:0]         recv_hi;
  logic [15:0]        crc_val;
  logic               frame_ok;
  cfs_pkg::crc_ctrl_t crc_ctrl;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= cfs_pkg::HEADER_RESET;
      crc_seed    <= cfs_pkg::SEED_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        cfs_pkg::CFG_HEADER: header_byte <= cfg.wdata[7:0];
        cfs_pkg::CFG_SEED:   crc_seed    <= cfg.wdata;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- window taps
  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_rot
    if (i == FRAME_BYTES - 1) begin : g_r1_wrap
      assign win_rot1[i] = win[0];
    end else begin : g_r1
      assign win_rot1[i] = win[i+1];
    end
    if (i + 2 >= FRAME_BYTES) begin : g_r2_wrap
      assign win_rot2[i] = win[i+2-FRAME_BYTES];
    end else begin : g_r2
      assign win_rot2[i] = win[i+2];
    end
  end

  // ---------------------------------------------------------------- CRC unit
  assign crc_ctrl.first = (cnt == '0);
  assign crc_ctrl.step  = (state == ST_CHECK) && (cnt <= CRC_END);

  cfs_crc16 u_crc (
    .clk  (clk),
    .ctrl (crc_ctrl),
    .seed (crc_seed),
    .data (win[0]),
    .crc  (crc_val)
  );

  // Last check cycle: entry 0 holds the low received CRC byte
  assign frame_ok = hdr_ok && (crc_val == {recv_hi, win[0]});

  // ---------------------------------------------------------------- handshakes
  assign rx.ready         = (state == ST_IDLE);
  assign frame.valid      = (state == ST_EMIT);
  assign frame.frame_byte = win[0];
  assign frame.frame_last = (cnt == LAST_IDX);

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (rx.valid) begin
            if (fill == LAST_IDX) begin
              state <= ST_CHECK;
              cnt   <= '0;
            end else begin
              fill <= fill + 1'b1;
            end
          end
        end
        ST_CHECK: begin
          if (cnt == LAST_IDX) begin
            cnt <= '0;
            if (frame_ok) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;  // fill stays at FRAME_BYTES-1 after the drop
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (frame.ready) begin
            if (cnt == LAST_IDX) begin
              cnt   <= '0;
              fill  <= '0;
              state <= ST_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          fill  <= '0;
          cnt   <= '0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- window data
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (rx.valid) begin
          win[fill] <= rx.rx_byte;
        end
      end
      ST_CHECK: begin
        if (cnt == '0) begin
          hdr_ok <= (win[0] == header_byte);
        end
        if (cnt == HI_IDX) begin
          recv_hi <= win[0];
        end
        // On a failed last step, rotating by two lands on the order with the oldest gone
        if (cnt == LAST_IDX && !frame_ok) begin
          win <= win_rot2;
        end else begin
          win <= win_rot1;
        end
      end
      ST_EMIT: begin
        if (frame.ready) begin
          win <= win_rot1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  // A byte that fills the window starts a check: no further byte taken next cycle
  a_fill_starts_check: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && fill == LAST_IDX) |=> !rx.ready)
    else $error("window full but input still ready");

  // After the final frame byte is taken the window is empty and input resumes
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && frame.frame_last) |=> (fill == '0 && rx.ready))
    else $error("window not emptied after frame");

  // A frame always opens on a non-final byte, straight after a check pass
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    $rose(frame.valid) |-> (!frame.frame_last && $past(state == ST_CHECK)))
    else $error("frame emission started badly");

  // Input is never taken while a frame is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(frame.valid && rx.ready))
    else $error("input ready during frame emission");
`endif

endmodule

>>> dv/crc16_checked_frame_sync_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-16 checked frame sync block.
// Depends on cfs_pkg, the cfs handshake interfaces and crc16_checked_frame_sync.
module crc16_checked_frame_sync_tb;

  localparam int FRAME_BYTES        = cfs_pkg::FRAME_BYTES_DEF;
  localparam int PHASE_ITEMS        = 72;                  // random items per config phase
  localparam int SETTLE_CYCLES      = 2 * FRAME_BYTES + 8; // check pass plus emit, with margin
  localparam int DRAIN_LIMIT        = 4000;
  localparam int CYCLE_LIMIT        = 400000;
  localparam int LONG_HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER_RESULTS = 40;
  localparam int PREDICTED          = -1;                  // table row left to the predictor

  // Indexes outside the register map: writes to these must be ignored
  localparam logic [cfs_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [cfs_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Directed rows either carry a literal byte or stand in for the trailing CRC of the
  // frame that currently sits aligned in the window.
  typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_HI, ROW_CRC_LO, ROW_CRC_BAD_LO} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    int         results;   // frame items this byte releases, or PREDICTED
  } stim_row_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_item_t;

  // Reset values: good frame with field extremes, then a frame with a broken CRC, then a
  // byte that exposes a header mismatch on the bytes left behind.
  stim_row_t directed_rows [21] = '{
    '{ROW_BYTE, 8'h61, 0}, '{ROW_BYTE, 8'h00, 0}, '{ROW_BYTE, 8'hFF, 0},
    '{ROW_BYTE, 8'h80, 0}, '{ROW_BYTE, 8'h01, 0}, '{ROW_BYTE, 8'h7F, 0},
    '{ROW_BYTE, 8'hFE, 0}, '{ROW_BYTE, 8'hAA, 0},
    '{ROW_CRC_HI, 8'h00, 0}, '{ROW_CRC_LO, 8'h00, FRAME_BYTES},
    '{ROW_BYTE, 8'h61, 0}, '{ROW_BYTE, 8'h12, 0}, '{ROW_BYTE, 8'h34, 0},
    '{ROW_BYTE, 8'h56, 0}, '{ROW_BYTE, 8'h78, 0}, '{ROW_BYTE, 8'h9A, 0},
    '{ROW_BYTE, 8'hBC, 0}, '{ROW_BYTE, 8'hDE, 0},
    '{ROW_CRC_HI, 8'h00, 0}, '{ROW_CRC_BAD_LO, 8'h00, 0},
    '{ROW_BYTE, 8'h00, 0}
  };

  logic clk = 1'b0;
  logic rst;

  cfs_cfg_if   cfg_ch ();
  cfs_byte_if  rx_ch ();
  cfs_frame_if frame_ch ();

  crc16_checked_frame_sync #(
    .FRAME_BYTES (FRAME_BYTES)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .rx    (rx_ch),
    .frame (frame_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Own copy of the sync state: window contents, fill level and the two registers
  logic [7:0]  win [FRAME_BYTES];
  int          win_fill;
  logic [7:0]  hdr_reg;
  logic [15:0] seed_reg;

  frame_item_t due_frame_bytes [$];   // frame items still owed by the block, oldest first

  int fail_count  = 0;
  int cycle_count = 0;
  bit no_idle     = 1'b0;

  // Sink side state, owned by the sink process
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          gap_left  = 0;
  int          taken     = 0;
  frame_item_t want;

  // One byte through the CCITT-FALSE shift register (MSB first, no reflection)
  function automatic logic [15:0] ccitt_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ cfs_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  // CRC over the payload part of the window (header up to the two CRC bytes)
  function automatic logic [15:0] window_crc();
    logic [15:0] crc;
    crc = seed_reg;
    for (int i = 0; i < FRAME_BYTES - 2; i++) crc = ccitt_fold(crc, win[i]);
    return crc;
  endfunction

  // Predicts the effect of one accepted byte; queues the frame items it releases.
  task automatic sync_window_push(input logic [7:0] b, output int produced);
    logic [15:0] recv;
    produced = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill < FRAME_BYTES) return;
    recv = {win[FRAME_BYTES-2], win[FRAME_BYTES-1]};
    if (win[0] != hdr_reg || window_crc() != recv) begin
      // no frame here: slide by one and keep scanning
      for (int i = 0; i < FRAME_BYTES - 1; i++) win[i] = win[i+1];
      win_fill = FRAME_BYTES - 1;
      return;
    end
    for (int i = 0; i < FRAME_BYTES; i++)
      due_frame_bytes.push_back('{frame_byte: win[i], frame_last: 1'(i == FRAME_BYTES - 1)});
    win_fill  = 0;
    produced  = FRAME_BYTES;
  endtask

  // Offer one byte, with an occasional idle burst first; returns at the accepting edge.
  // valid stays high afterwards so back-to-back bytes need no second assignment.
  task automatic push_rx(input logic [7:0] b, output int produced);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sync_window_push(b, produced);
  endtask

  // Register write; valid is left high for a following write and lowered by the caller
  task automatic write_reg(input logic [cfs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [cfs_pkg::CFG_DATA_W-1:0]  data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      cfs_pkg::CFG_HEADER: hdr_reg = data[7:0];
      cfs_pkg::CFG_SEED:   seed_reg = data;
      default: ;
    endcase
  endtask

  // Wait until every owed frame item has come back, then give the block time to finish
  // any check that releases nothing.
  task automatic drain_frames();
    int waited;
    waited = 0;
    while (due_frame_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_frame_bytes.size() != 0) begin
      $error("frame_byte: expected %0d more items, actual none", due_frame_bytes.size());
      fail_count++;
      due_frame_bytes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random burst. Mostly well-formed frames with random payload so that the check
  // path is exercised; the rest are corrupted frames, wrong headers, cut-off frames and
  // plain line noise, which also leave partial windows for later frames to slide past.
  task automatic send_random_burst(inout int sent);
    logic [7:0]  burst [$];
    logic [15:0] crc;
    int          pick;
    int          pos;
    int          cut;
    int          produced;
    pick = $urandom_range(0, 99);
    if (pick < 88) begin
      burst.push_back(hdr_reg);
      for (int i = 1; i < FRAME_BYTES - 2; i++) burst.push_back(8'($urandom_range(0, 255)));
      crc = seed_reg;
      foreach (burst[i]) crc = ccitt_fold(crc, burst[i]);
      burst.push_back(crc[15:8]);
      burst.push_back(crc[7:0]);
      if (pick >= 55 && pick < 70) begin
        // single bit error anywhere in the frame
        pos = $urandom_range(0, FRAME_BYTES - 1);
        burst[pos] ^= 8'(1 << $urandom_range(0, 7));
      end else if (pick >= 70 && pick < 78) begin
        burst[0] = hdr_reg ^ 8'($urandom_range(1, 255));
      end else if (pick >= 78) begin
        cut = $urandom_range(1, FRAME_BYTES - 1);
        while (burst.size() > cut) void'(burst.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(0, 255)));
    end
    foreach (burst[i]) begin
      push_rx(burst[i], produced);
      sent++;
    end
  endtask

  // Frame sink: checks each taken item against the oldest owed one and paces ready.
  // Once, after enough results, it holds off for a long stretch so the block backs up
  // and stalls its byte input while the source keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (due_frame_bytes.size() == 0) begin
          $error("frame_byte: expected nothing, actual %02h (frame_last %0b)",
                 frame_ch.frame_byte, frame_ch.frame_last);
          fail_count++;
        end else begin
          want = due_frame_bytes.pop_front();
          if (frame_ch.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %02h, actual %02h",
                   want.frame_byte, frame_ch.frame_byte);
            fail_count++;
          end
          if (frame_ch.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, actual %0b",
                   want.frame_last, frame_ch.frame_last);
            fail_count++;
          end
        end
        taken++;
      end

      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else if (!hold_done && taken >= HOLD_AFTER_RESULTS) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES - 1;
        frame_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        frame_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 11);
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int          produced;
    int          sent;
    logic [7:0]  b;
    logic [15:0] crc;
    logic [15:0] hdr_w;
    logic [15:0] seed_w;

    rst              = 1'b1;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = 8'h00;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = cfs_pkg::CFG_HEADER;
    cfg_ch.wdata     = '0;

    hdr_reg  = cfs_pkg::HEADER_RESET;
    seed_reg = cfs_pkg::SEED_RESET;
    win_fill = 0;
    foreach (win[i]) win[i] = 8'h00;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset register values
    foreach (directed_rows[r]) begin
      crc = window_crc();
      case (directed_rows[r].kind)
        ROW_CRC_HI:     b = crc[15:8];
        ROW_CRC_LO:     b = crc[7:0];
        ROW_CRC_BAD_LO: b = crc[7:0] ^ 8'h01;
        default:        b = directed_rows[r].value;
      endcase
      push_rx(b, produced);
      if (directed_rows[r].results != PREDICTED && produced != directed_rows[r].results) begin
        $error("results: expected %0d, actual %0d", directed_rows[r].results, produced);
        fail_count++;
      end
    end
    rx_ch.valid <= 1'b0;
    drain_frames();

    // Random phases: all-zero header and seed, all-ones, then two random settings.
    // Header writes carry junk in the upper byte, which must be dropped; the third
    // phase also pokes the unmapped indexes. The last phase runs without idling.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          hdr_w  = {8'($urandom_range(1, 255)), 8'h00};
          seed_w = 16'h0000;
        end
        1: begin
          hdr_w  = {8'($urandom_range(0, 255)), 8'hFF};
          seed_w = 16'hFFFF;
        end
        default: begin
          hdr_w  = 16'($urandom);
          seed_w = 16'($urandom);
        end
      endcase
      write_reg(cfs_pkg::CFG_HEADER, hdr_w);
      write_reg(cfs_pkg::CFG_SEED, seed_w);
      if (phase == 2) begin
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
      end
      cfg_ch.valid <= 1'b0;

      no_idle = (phase == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_burst(sent);
      rx_ch.valid <= 1'b0;
      drain_frames();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
